### hdl/maf_pkg.sv
// Shared constants for the moving average filter.
package maf_pkg;

  // Width of the window register and of the fill count
  localparam int FILL_W = 7;
  // Largest fill count the window register can ask for
  localparam logic [FILL_W-1:0] FILL_MAX = 7'd127;
  // Window size after reset
  localparam logic [FILL_W-1:0] WIN_RESET = 7'd64;
  // Width of the input words and of the average
  localparam int OUT_W = 32;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_OFFSET = 1'b1;

endpackage

### hdl/moving_average_filter.sv
// Moving average filter top level: sample ring, running sum, sequencer and output register.
// A sample word (req_type 0) updates the running sum on the shared adder in S_SUB and S_ADD,
// starts the divider in S_DIVGO, waits in S_DIVW for the one-bit-per-cycle divider, and then
// loads its result into the output register once that register is free. An offset word
// (req_type 1) gives no result, walking the filled ring entries one per cycle through the
// single-port-read ring memory. in_stall_o is high while a word is in work; a finished
// result waits in the output register so the next word can be taken meanwhile. Writing the
// window register empties the filter; no clearing pass is needed since only the values of
// filled entries are ever used.
module moving_average_filter import maf_pkg::*; #(
  parameter int MAX_DEPTH    = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_we_i,
  input  logic [FILL_W-1:0]    cfg_wdata_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic signed [OUT_W-1:0] sample_value_i,
  input  logic signed [OUT_W-1:0] offset_value_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [OUT_W-1:0] average_o,
  output logic [FILL_W-1:0]    filled_count_o
);

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int SUMW = SAMPLE_WIDTH + 6;
  localparam int CW   = (AW + 1 > FILL_W) ? AW + 1 : FILL_W;
  localparam logic [FILL_W-1:0] DEPTH_CAP =
    (MAX_DEPTH > 127) ? FILL_MAX : FILL_W'(MAX_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUB   = 6'b000010,
    S_ADD   = 6'b000100,
    S_DIVGO = 6'b001000,
    S_DIVW  = 6'b010000,
    S_OFS   = 6'b100000
  } state_e;

  state_e                  st_q, st_d;
  logic [FILL_W-1:0]       win_q;
  logic [AW-1:0]           pos_q, pos_d;
  logic [SUMW-1:0]         sum_q;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [SAMPLE_WIDTH-1:0] smp_q;
  logic [OUT_W-1:0]        ofs_q;
  logic [CW-1:0]           rd_cnt_q, rd_cnt_d;
  logic                    wb_pend_q, wb_pend_d;
  logic [AW-1:0]           wb_idx_q;
  logic                    out_valid_q;
  logic [OUT_W-1:0]        avg_q;
  logic [FILL_W-1:0]       cnt_out_q;

  logic [SAMPLE_WIDTH-1:0] ring_mem [MAX_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rdata_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  logic [SAMPLE_WIDTH-1:0] mem_wdata;

  logic [FILL_W-1:0]       win_eff;
  logic                    full;
  logic                    in_acc;
  logic [CW-1:0]           pos_inc;
  logic                    rd_issue;

  logic                    sum_we;
  logic                    add_sub;
  logic [SUMW-1:0]         add_op;
  logic [SUMW-1:0]         sum_nx;

  logic                    div_done;
  logic [OUT_W-1:0]        div_quot;
  logic                    out_free;
  logic                    out_load;

  // Effective window: zero means one, large values cap at the ring depth (at FILL_MAX for deeper rings)
  always_comb begin
    if (win_q == '0) begin
      win_eff = FILL_W'(1);
    end else if (win_q > DEPTH_CAP) begin
      win_eff = DEPTH_CAP;
    end else begin
      win_eff = win_q;
    end
  end

  assign full     = (fill_q >= win_eff);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign pos_inc  = CW'(pos_q) + CW'(1);
  assign rd_issue = (st_q == S_OFS) && (rd_cnt_q < CW'(fill_q));

  // Shared adder for the running sum
  always_comb begin
    sum_we  = 1'b0;
    add_sub = 1'b0;
    add_op  = '0;
    case (st_q)
      S_SUB: begin
        sum_we  = full;
        add_sub = 1'b1;
        add_op  = SUMW'($signed(rdata_q));
      end
      S_ADD: begin
        sum_we = 1'b1;
        add_op = SUMW'($signed(smp_q));
      end
      S_OFS: begin
        sum_we = wb_pend_q;
        add_op = SUMW'($signed(ofs_q));
      end
      default: begin
        sum_we = 1'b0;
      end
    endcase
  end

  assign sum_nx = sum_q + (add_sub ? ~add_op : add_op) + SUMW'(add_sub);

  // Ring memory port control
  always_comb begin
    mem_raddr = (st_q == S_OFS) ? rd_cnt_q[AW-1:0] : pos_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = smp_q;
    if (st_q == S_SUB) begin
      mem_we = 1'b1;
    end else if (st_q == S_OFS && wb_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wb_idx_q;
      mem_wdata = rdata_q + SAMPLE_WIDTH'($signed(ofs_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= ring_mem[mem_raddr];
  end

  // Output register hand-off
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (st_q == S_DIVW) && div_done && out_free;

  // Sequencer
  always_comb begin
    st_d      = st_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    rd_cnt_d  = rd_cnt_q;
    wb_pend_d = rd_issue;
    case (st_q)
      S_IDLE: begin
        rd_cnt_d = '0;
        if (in_acc) begin
          st_d = (req_type_i == REQ_OFFSET) ? S_OFS : S_SUB;
        end
      end
      S_SUB: begin
        if (!full) begin
          fill_d = fill_q + FILL_W'(1);
        end
        st_d = S_ADD;
      end
      S_ADD: begin
        pos_d = (pos_inc >= CW'(win_eff)) ? '0 : pos_inc[AW-1:0];
        st_d  = S_DIVGO;
      end
      S_DIVGO: begin
        st_d = S_DIVW;
      end
      S_DIVW: begin
        if (out_load) begin
          st_d = S_IDLE;
        end
      end
      S_OFS: begin
        if (rd_issue) begin
          rd_cnt_d = rd_cnt_q + CW'(1);
        end else if (!wb_pend_q) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      win_q       <= WIN_RESET;
      pos_q       <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
      rd_cnt_q    <= '0;
      wb_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      rd_cnt_q  <= rd_cnt_d;
      wb_pend_q <= wb_pend_d;
      if (cfg_we_i) begin
        win_q  <= cfg_wdata_i;
        pos_q  <= '0;
        sum_q  <= '0;
        fill_q <= '0;
      end else begin
        pos_q  <= pos_d;
        fill_q <= fill_d;
        if (sum_we) begin
          sum_q <= sum_nx;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Word payload and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= SAMPLE_WIDTH'(sample_value_i);
      ofs_q <= offset_value_i;
    end
    wb_idx_q <= rd_cnt_q[AW-1:0];
    if (out_load) begin
      avg_q     <= div_quot;
      cnt_out_q <= fill_q;
    end
  end

  maf_div #(
    .DW (SUMW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (st_q == S_DIVGO),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_stall_o     = (st_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign average_o      = avg_q;
  assign filled_count_o = cnt_out_q;

  // Checks
  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_eff)
    else $error("fill count above window");

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < CW'(win_eff))
    else $error("write index outside window");

  a_walk_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OFS) && wb_pend_q |-> CW'(wb_idx_q) < CW'(fill_q))
    else $error("offset walk beyond filled entries");

  a_result_needs_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(div_done))
    else $error("result loaded before division finished");

endmodule

### hdl/maf_div.sv
// Serial signed divider: sum by fill count, one quotient bit per cycle, saturated result.
module maf_div import maf_pkg::*; #(
  parameter int DW = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [FILL_W-1:0]   divisor_i,
  output logic                done_o,
  output logic [OUT_W-1:0]    quotient_o
);

  localparam int CNTW = $clog2(DW + 1);
  localparam int QW   = (DW + 1 > OUT_W + 1) ? DW + 1 : OUT_W + 1;

  localparam logic signed [QW-1:0] Q_MAX = {{(QW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {{(QW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                neg_q, neg_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]       acc_q, acc_d;
  logic [FILL_W-1:0]   rem_q, rem_d;
  logic [FILL_W-1:0]   dvs_q, dvs_d;

  logic [DW-1:0]       mag_in;
  logic [FILL_W:0]     rem_sh;
  logic [FILL_W:0]     rem_sub;
  logic                ge;
  logic signed [QW-1:0] mag_x;
  logic signed [QW-1:0] q_s;

  // Magnitude of the dividend; the most negative value still fits unsigned
  assign mag_in = dividend_i[DW-1] ? (~dividend_i + DW'(1)) : dividend_i;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh  = {rem_q, acc_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  // Sequencer
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      neg_d  = dividend_i[DW-1];
      cnt_d  = '0;
      acc_d  = mag_in;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      acc_d = {acc_q[DW-2:0], ge};
      rem_d = ge ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // Apply sign and clamp to the output range
  assign mag_x = QW'(acc_q);
  assign q_s   = neg_q ? -mag_x : mag_x;

  always_comb begin
    if (q_s > Q_MAX) begin
      quotient_o = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (q_s < Q_MIN) begin
      quotient_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      quotient_o = q_s[OUT_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule
